// ===== src/assert_macros.svh =====
// assertion macros shared by the receiver modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: implication");

// next-cycle implication, checked out of reset
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

// plain invariant, checked out of reset
`define ASSERT_ALW(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error("assertion failed: invariant");

`endif

// ===== src/cfrx_pkg.sv =====
// types, constants and crc helper for the command frame receiver
package cfrx_pkg;

	// frame layout
	localparam int FRAME_BYTES = 14;
	localparam int STORE_BYTES = FRAME_BYTES - 1;
	localparam int CNT_W       = 4;
	localparam int IDX_W       = 4;
	localparam logic [CNT_W-1:0] COUNT_MAX  = 4'd15;
	localparam logic [CNT_W-1:0] POS_SINGLE = 4'd0;
	localparam logic [CNT_W-1:0] POS_CRC_LO = 4'd4;
	localparam logic [CNT_W-1:0] POS_CRC_HI = 4'd11;
	localparam logic [CNT_W-1:0] POS_LAST   = 4'(FRAME_BYTES - 1);
	localparam logic [CNT_W-1:0] POS_STORE  = 4'(STORE_BYTES);

	// header and mode bytes
	localparam logic [7:0] HDR_B0    = 8'h01;
	localparam logic [7:0] HDR_B1    = 8'hAB;
	localparam logic [7:0] HDR_B2    = 8'hCD;
	localparam logic [7:0] HDR_B3    = 8'h05;
	localparam logic [7:0] MODE_HI   = 8'h00;
	localparam logic [7:0] MODE_IAP  = 8'h10;
	localparam logic [7:0] MODE_APP  = 8'h01;
	localparam logic [15:0] CRC_POLY = 16'h1021;

	// event codes
	localparam logic [2:0] EV_IGNORED  = 3'd0;
	localparam logic [2:0] EV_CONFIG   = 3'd1;
	localparam logic [2:0] EV_SETTING  = 3'd2;
	localparam logic [2:0] EV_REQUEST  = 3'd3;
	localparam logic [2:0] EV_ACK      = 3'd4;
	localparam logic [2:0] EV_FRAME_OK = 3'd5;
	localparam logic [2:0] EV_CRC_BAD  = 3'd6;
	localparam logic [2:0] EV_HDR_BAD  = 3'd7;

	// device stages
	localparam logic [1:0] STAGE_TOP     = 2'd1;
	localparam logic [1:0] STAGE_SETTING = 2'd2;
	localparam logic [1:0] STAGE_UPGRADE = 2'd3;

	// mode codes
	localparam logic [1:0] MODE_NONE = 2'd0;
	localparam logic [1:0] MODE_IS_IAP = 2'd1;
	localparam logic [1:0] MODE_IS_APP = 2'd2;

	// register indexes
	localparam logic [2:0] REG_CRC_INIT  = 3'd0;
	localparam logic [2:0] REG_CRC_XOR   = 3'd1;
	localparam logic [2:0] REG_CODE_CFG  = 3'd2;
	localparam logic [2:0] REG_CODE_SET  = 3'd3;
	localparam logic [2:0] REG_CODE_REQ  = 3'd4;
	localparam logic [2:0] REG_CODE_ACK  = 3'd5;

	// configuration registers
	typedef struct packed {
		logic [15:0] crc_init;
		logic [15:0] crc_xorout;
		logic [7:0]  code_configure;
		logic [7:0]  code_setting;
		logic [7:0]  code_request;
		logic [7:0]  code_ack;
	} cfg_t;

	// one classified message handed from front to back
	typedef struct packed {
		logic [2:0] event_res;
		logic [1:0] mode_seen;
		logic [7:0] ip_b2;
		logic [7:0] ip_b3;
		logic [7:0] gw_b2;
		logic [7:0] gw_b3;
		logic [7:0] mac_b4;
		logic [7:0] mac_b5;
	} job_t;

	// crc-16 update over one byte, msb first
	function automatic logic [15:0] crc_feed(input logic [15:0] rem, input logic [7:0] b);
		logic [15:0] r;
		r = rem ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			if (r[15]) begin
				r = {r[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				r = {r[14:0], 1'b0};
			end
		end
		return r;
	endfunction

endpackage

// ===== src/cfrx_if.sv =====
// valid/ready channel interfaces for received bytes and results

// received byte channel
interface cfrx_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;
	logic       msg_end;

	modport source (output valid, output rx_byte, output msg_end, input ready);
	modport sink   (input valid, input rx_byte, input msg_end, output ready);
endinterface

// result channel
interface cfrx_res_if;
	logic       valid;
	logic       ready;
	logic [2:0] event_res;
	logic [1:0] stage;
	logic [1:0] mode_seen;
	logic [7:0] ip_b2;
	logic [7:0] ip_b3;
	logic [7:0] gw_b2;
	logic [7:0] gw_b3;
	logic [7:0] mac_b4;
	logic [7:0] mac_b5;

	modport source (output valid, output event_res, output stage, output mode_seen,
		output ip_b2, output ip_b3, output gw_b2, output gw_b3, output mac_b4,
		output mac_b5, input ready);
	modport sink (input valid, input event_res, input stage, input mode_seen,
		input ip_b2, input ip_b3, input gw_b2, input gw_b3, input mac_b4,
		input mac_b5, output ready);
endinterface

// ===== src/cfrx_front.sv =====
// front end: counts, buffers and crc-checks bytes, classifies each message
`include "assert_macros.svh"
module cfrx_front import cfrx_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	cfrx_byte_if.sink  rx,
	input  logic       full,
	output logic       push,
	output job_t       push_job
);

	logic [CNT_W-1:0] count_q;
	logic [15:0]      crc_q;
	logic [7:0]       frame_q [STORE_BYTES];
	logic             acc;
	logic [CNT_W-1:0] pos;
	logic             hdr_ok;
	logic             crc_ok;
	logic [15:0]      got;

	assign rx.ready = !full;
	assign acc      = rx.valid && rx.ready;
	assign push     = acc && rx.msg_end;
	assign pos      = count_q;

	// byte counter, saturating, cleared at message end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (acc) begin
			if (rx.msg_end) begin
				count_q <= '0;
			end else if (count_q != COUNT_MAX) begin
				count_q <= count_q + 1'b1;
			end
		end
	end

	// running crc over the payload bytes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= '0;
		end else if (acc) begin
			if (pos == POS_CRC_LO) begin
				crc_q <= crc_feed(cfg.crc_init, rx.rx_byte);
			end else if (pos > POS_CRC_LO && pos <= POS_CRC_HI) begin
				crc_q <= crc_feed(crc_q, rx.rx_byte);
			end
		end
	end

	// frame buffer, last byte is taken straight from the channel
	always_ff @(posedge clk) begin
		if (acc && pos < POS_STORE) begin
			frame_q[pos[IDX_W-1:0]] <= rx.rx_byte;
		end
	end

	// classification of the message that ends with this byte
	assign hdr_ok = frame_q[0] == HDR_B0 && frame_q[1] == HDR_B1 &&
		frame_q[2] == HDR_B2 && frame_q[3] == HDR_B3;
	assign got    = {frame_q[STORE_BYTES-1], rx.rx_byte};
	assign crc_ok = got == (crc_q ^ cfg.crc_xorout);

	always_comb begin
		push_job = '0;
		if (pos == POS_SINGLE) begin
			priority if (rx.rx_byte == cfg.code_configure) begin
				push_job.event_res = EV_CONFIG;
			end else if (rx.rx_byte == cfg.code_setting) begin
				push_job.event_res = EV_SETTING;
			end else if (rx.rx_byte == cfg.code_request) begin
				push_job.event_res = EV_REQUEST;
			end else if (rx.rx_byte == cfg.code_ack) begin
				push_job.event_res = EV_ACK;
			end else begin
				push_job.event_res = EV_IGNORED;
			end
		end else if (pos == POS_LAST) begin
			priority if (!hdr_ok) begin
				push_job.event_res = EV_HDR_BAD;
			end else if (!crc_ok) begin
				push_job.event_res = EV_CRC_BAD;
			end else begin
				push_job.event_res = EV_FRAME_OK;
				if (frame_q[4] == MODE_HI && frame_q[5] == MODE_IAP) begin
					push_job.mode_seen = MODE_IS_IAP;
				end else if (frame_q[4] == MODE_HI && frame_q[5] == MODE_APP) begin
					push_job.mode_seen = MODE_IS_APP;
				end
				push_job.ip_b2  = frame_q[6];
				push_job.ip_b3  = frame_q[7];
				push_job.gw_b2  = frame_q[8];
				push_job.gw_b3  = frame_q[9];
				push_job.mac_b4 = frame_q[10];
				push_job.mac_b5 = frame_q[11];
			end
		end
	end

	`ASSERT_NXT(a_count_clears, clk, arst_n, push, count_q == '0)
	`ASSERT_IMP(a_no_push_full, clk, arst_n, full, !push)

endmodule

// ===== src/cfrx_fifo.sv =====
// short queue of classified messages between front and back
`include "assert_macros.svh"
module cfrx_fifo import cfrx_pkg::*; #(
	parameter int DEPTH = 2
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	output logic full,
	input  logic pop,
	output logic not_empty,
	output job_t pop_job
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_QW = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_QW-1:0] CNT_FULL = CNT_QW'(DEPTH);

	job_t              mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_QW-1:0] count_q;
	logic              do_push;
	logic              do_pop;

	assign full      = count_q == CNT_FULL;
	assign not_empty = count_q != '0;
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;
	assign pop_job   = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	`ASSERT_ALW(a_count_range, clk, arst_n, count_q <= CNT_FULL)
	`ASSERT_NXT(a_full_holds, clk, arst_n, full && !pop, full)

endmodule

// ===== src/cfrx_back.sv =====
// back end: applies stage changes and holds the result register
`include "assert_macros.svh"
module cfrx_back import cfrx_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       not_empty,
	input  job_t       pop_job,
	output logic       pop,
	cfrx_res_if.source res
);

	logic [1:0] dev_stage_q;
	logic [1:0] next_stage;
	logic       out_valid_q;
	job_t       out_job_q;
	logic [1:0] out_stage_q;

	assign pop = not_empty && (!out_valid_q || res.ready);

	// stage after this message
	always_comb begin
		unique case (pop_job.event_res)
			EV_CONFIG:  next_stage = STAGE_TOP;
			EV_SETTING: next_stage = STAGE_SETTING;
			EV_REQUEST: next_stage = STAGE_UPGRADE;
			default:    next_stage = dev_stage_q;
		endcase
	end

	// control: device stage and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_stage_q <= STAGE_TOP;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				dev_stage_q <= next_stage;
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (pop) begin
			out_job_q   <= pop_job;
			out_stage_q <= next_stage;
		end
	end

	assign res.valid     = out_valid_q;
	assign res.event_res = out_job_q.event_res;
	assign res.stage     = out_stage_q;
	assign res.mode_seen = out_job_q.mode_seen;
	assign res.ip_b2     = out_job_q.ip_b2;
	assign res.ip_b3     = out_job_q.ip_b3;
	assign res.gw_b2     = out_job_q.gw_b2;
	assign res.gw_b3     = out_job_q.gw_b3;
	assign res.mac_b4    = out_job_q.mac_b4;
	assign res.mac_b5    = out_job_q.mac_b5;

	`ASSERT_ALW(a_stage_valid, clk, arst_n, dev_stage_q != 2'd0)
	`ASSERT_NXT(a_stage_follows, clk, arst_n, pop, out_stage_q == dev_stage_q)

endmodule

// ===== src/command_frame_receiver_top.sv =====
// Command frame receiver: one byte accepted per cycle, back to back, while the message queue is not full.
// A message's result passes through the message queue and then the result register before it is valid.
// Sustained rate is one byte per cycle; a result waiting on the output stalls only once the
// message queue (QUEUE_DEPTH entries) is full.
// Reset is asynchronous: counter, crc and queue clear, stage returns to top, registers take their
// reset values; the frame buffer is not cleared.
module command_frame_receiver_top import cfrx_pkg::*; #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	cfrx_byte_if.sink   rx,
	cfrx_res_if.source  res
);

	cfg_t       cfg_q;
	logic [2:0] reg_idx;
	logic       wr_en;
	logic       push;
	logic       full;
	logic       pop;
	logic       not_empty;
	job_t       push_job;
	job_t       pop_job;

	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];
	assign wr_en   = psel && penable && pwrite && pready;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.crc_init       <= 16'd0;
			cfg_q.crc_xorout     <= 16'd0;
			cfg_q.code_configure <= 8'd0;
			cfg_q.code_setting   <= 8'd0;
			cfg_q.code_request   <= 8'd67;
			cfg_q.code_ack       <= 8'd6;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_CRC_INIT: cfg_q.crc_init       <= pwdata[15:0];
				REG_CRC_XOR:  cfg_q.crc_xorout     <= pwdata[15:0];
				REG_CODE_CFG: cfg_q.code_configure <= pwdata[7:0];
				REG_CODE_SET: cfg_q.code_setting   <= pwdata[7:0];
				REG_CODE_REQ: cfg_q.code_request   <= pwdata[7:0];
				REG_CODE_ACK: cfg_q.code_ack       <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	// register read mux
	always_comb begin
		unique case (reg_idx)
			REG_CRC_INIT: prdata = {16'd0, cfg_q.crc_init};
			REG_CRC_XOR:  prdata = {16'd0, cfg_q.crc_xorout};
			REG_CODE_CFG: prdata = {24'd0, cfg_q.code_configure};
			REG_CODE_SET: prdata = {24'd0, cfg_q.code_setting};
			REG_CODE_REQ: prdata = {24'd0, cfg_q.code_request};
			REG_CODE_ACK: prdata = {24'd0, cfg_q.code_ack};
			default:      prdata = 32'd0;
		endcase
	end

	cfrx_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.rx       (rx),
		.full     (full),
		.push     (push),
		.push_job (push_job)
	);

	cfrx_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_job  (push_job),
		.full      (full),
		.pop       (pop),
		.not_empty (not_empty),
		.pop_job   (pop_job)
	);

	cfrx_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.not_empty (not_empty),
		.pop_job   (pop_job),
		.pop       (pop),
		.res       (res)
	);

endmodule

// ===== dv/cfrx_checker.sv =====
// checker for the command frame receiver: tracks register writes, predicts each message result
module cfrx_checker import cfrx_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	cfrx_byte_if        rx,
	cfrx_res_if         res,
	output int          fail_count,
	output int          report_count,
	output int          waiting
);
	timeunit 1ns;
	timeprecision 1ps;

	// one classified message as seen on the result channel
	typedef struct packed {
		logic [2:0] ev;
		logic [1:0] stage;
		logic [1:0] mode;
		logic [7:0] ip_b2;
		logic [7:0] ip_b3;
		logic [7:0] gw_b2;
		logic [7:0] gw_b3;
		logic [7:0] mac_b4;
		logic [7:0] mac_b5;
	} report_t;

	report_t pending_reports[$];

	// register copies
	logic [15:0] seed_crc;
	logic [15:0] xor_crc;
	logic [7:0]  cfg_code;
	logic [7:0]  set_code;
	logic [7:0]  req_code;
	logic [7:0]  ack_code;

	// receiver state
	logic [3:0]  msg_len;
	logic [7:0]  frame_buf [FRAME_BYTES];
	logic [15:0] crc_acc;
	logic [1:0]  dev_stage_q;

	initial begin
		fail_count   = 0;
		report_count = 0;
		waiting      = 0;
	end

	// msb-first crc-16 over one byte
	function automatic logic [15:0] crc16_step(input logic [15:0] rem, input logic [7:0] d);
		logic [15:0] r;
		r = rem ^ {d, 8'h00};
		for (int k = 0; k < 8; k++) begin
			r = r[15] ? ({r[14:0], 1'b0} ^ CRC_POLY) : {r[14:0], 1'b0};
		end
		return r;
	endfunction

	// take one accepted byte; queue the expected report when the message ends
	task automatic absorb_byte(input logic [7:0] b, input logic last);
		logic [3:0] pos;
		logic [3:0] len;
		report_t r;
		pos = msg_len;
		if (pos < FRAME_BYTES) begin
			frame_buf[pos] = b;
		end
		if (pos == POS_CRC_LO) begin
			crc_acc = crc16_step(seed_crc, b);
		end else if (pos > POS_CRC_LO && pos <= POS_CRC_HI) begin
			crc_acc = crc16_step(crc_acc, b);
		end
		len = (pos < COUNT_MAX) ? pos + 4'd1 : COUNT_MAX;
		msg_len = len;
		if (last) begin
			r = '0;
			if (len == 4'd1) begin
				// control codes, first match wins
				if (b == cfg_code) begin
					r.ev = EV_CONFIG;
					dev_stage_q = STAGE_TOP;
				end else if (b == set_code) begin
					r.ev = EV_SETTING;
					dev_stage_q = STAGE_SETTING;
				end else if (b == req_code) begin
					r.ev = EV_REQUEST;
					dev_stage_q = STAGE_UPGRADE;
				end else if (b == ack_code) begin
					r.ev = EV_ACK;
				end
			end else if (len == 4'(FRAME_BYTES)) begin
				if (frame_buf[0] != HDR_B0 || frame_buf[1] != HDR_B1 ||
						frame_buf[2] != HDR_B2 || frame_buf[3] != HDR_B3) begin
					r.ev = EV_HDR_BAD;
				end else if ({frame_buf[12], frame_buf[13]} != (crc_acc ^ xor_crc)) begin
					r.ev = EV_CRC_BAD;
				end else begin
					r.ev = EV_FRAME_OK;
					if (frame_buf[4] == MODE_HI && frame_buf[5] == MODE_IAP) begin
						r.mode = MODE_IS_IAP;
					end else if (frame_buf[4] == MODE_HI && frame_buf[5] == MODE_APP) begin
						r.mode = MODE_IS_APP;
					end
					r.ip_b2  = frame_buf[6];
					r.ip_b3  = frame_buf[7];
					r.gw_b2  = frame_buf[8];
					r.gw_b3  = frame_buf[9];
					r.mac_b4 = frame_buf[10];
					r.mac_b5 = frame_buf[11];
				end
			end
			r.stage = dev_stage_q;
			pending_reports.push_back(r);
			msg_len = '0;
		end
	endtask

	// watch the channels and the register port
	always @(posedge clk or negedge arst_n) begin
		report_t got;
		report_t exp;
		if (!arst_n) begin
			seed_crc    = '0;
			xor_crc     = '0;
			cfg_code    = 8'd0;
			set_code    = 8'd0;
			req_code    = 8'd67;
			ack_code    = 8'd6;
			msg_len     = '0;
			crc_acc     = '0;
			dev_stage_q = STAGE_TOP;
			pending_reports.delete();
		end else begin
			// compare an accepted result with the oldest prediction
			if (res.valid && res.ready) begin
				got = {res.event_res, res.stage, res.mode_seen, res.ip_b2, res.ip_b3,
					res.gw_b2, res.gw_b3, res.mac_b4, res.mac_b5};
				if (pending_reports.size() == 0) begin
					fail_count++;
					if (fail_count <= 10) begin
						$display("unexpected result: ev %0d stage %0d mode %0d bytes %h",
							got.ev, got.stage, got.mode, got[47:0]);
					end
				end else begin
					exp = pending_reports.pop_front();
					report_count++;
					if (got !== exp) begin
						fail_count++;
						if (fail_count <= 10) begin
							$display("result %0d mismatch: expected ev %0d stage %0d mode %0d bytes %h",
								report_count, exp.ev, exp.stage, exp.mode, exp[47:0]);
							$display("    got ev %0d stage %0d mode %0d bytes %h",
								got.ev, got.stage, got.mode, got[47:0]);
						end
					end
				end
			end
			// register writes
			if (psel && penable && pwrite && pready) begin
				case (paddr[4:2])
					REG_CRC_INIT: seed_crc = pwdata[15:0];
					REG_CRC_XOR:  xor_crc  = pwdata[15:0];
					REG_CODE_CFG: cfg_code = pwdata[7:0];
					REG_CODE_SET: set_code = pwdata[7:0];
					REG_CODE_REQ: req_code = pwdata[7:0];
					REG_CODE_ACK: ack_code = pwdata[7:0];
					default: ;
				endcase
			end
			// received byte
			if (rx.valid && rx.ready) begin
				absorb_byte(rx.rx_byte, rx.msg_end);
			end
		end
		waiting = pending_reports.size();
	end

endmodule

// ===== dv/command_frame_receiver_top_test.sv =====
// stimulus and verdict for the command frame receiver: messages, register settings, flow control
module command_frame_receiver_top_test import cfrx_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int BYTE_BUDGET  = 1250;
	localparam int PHASE_BYTES  = 160;
	localparam int CYCLE_LIMIT  = 400000;

	typedef enum int {
		MSG_CODE,
		MSG_FRAME_OK,
		MSG_FRAME_CRC_BAD,
		MSG_FRAME_HDR_BAD,
		MSG_ODD_LEN
	} msg_kind_t;

	// mode byte choices for built frames
	localparam int PICK_IAP = 0;
	localparam int PICK_APP = 1;
	localparam int PICK_ANY = 2;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [4:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	cfrx_byte_if rx_ch();
	cfrx_res_if  res_ch();

	int chk_fails;
	int chk_reports;
	int chk_waiting;

	// register values as last written
	logic [15:0] tb_crc_init = 16'h0000;
	logic [15:0] tb_crc_xor  = 16'h0000;
	logic [7:0]  tb_code_cfg = 8'd0;
	logic [7:0]  tb_code_set = 8'd0;
	logic [7:0]  tb_code_req = 8'd67;
	logic [7:0]  tb_code_ack = 8'd6;

	logic [7:0] msg_q[$];
	int bytes_sent  = 0;
	int msgs_sent   = 0;
	int settings    = 0;
	int burst_left  = 0;
	int cycle_count = 0;

	logic [15:0] stall_mask = 16'hFFFF;
	logic [3:0]  stall_pos  = '0;
	int          stall_left = 0;

	command_frame_receiver_top DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.rx      (rx_ch),
		.res     (res_ch)
	);

	cfrx_checker chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.pready       (pready),
		.rx           (rx_ch),
		.res          (res_ch),
		.fail_count   (chk_fails),
		.report_count (chk_reports),
		.waiting      (chk_waiting)
	);

	// clock
	initial clk = 1'b0;
	always #2 clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("TEST FAILED");
			$finish;
		end
	end

	// result side back-pressure, pattern redrawn after a random run length
	always @(negedge clk) begin
		if (stall_left == 0) begin
			stall_left = $urandom_range(20, 120);
			case ($urandom_range(0, 3))
				0: stall_mask = 16'hFFFF;
				1: stall_mask = 16'($urandom()) | 16'h0001;
				2: stall_mask = 16'h0001;
				default: stall_mask = 16'hAAAA;
			endcase
		end
		stall_left--;
		stall_pos++;
		res_ch.ready = stall_mask[stall_pos];
	end

	// one register write over the config port
	task automatic reg_write(input logic [2:0] idx, input logic [15:0] value);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b1;
		paddr   = {idx, 2'b00};
		pwdata  = 32'(value);
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
		case (idx)
			REG_CRC_INIT: tb_crc_init = value;
			REG_CRC_XOR:  tb_crc_xor  = value;
			REG_CODE_CFG: tb_code_cfg = value[7:0];
			REG_CODE_SET: tb_code_set = value[7:0];
			REG_CODE_REQ: tb_code_req = value[7:0];
			REG_CODE_ACK: tb_code_ack = value[7:0];
			default: ;
		endcase
	endtask

	// write all six registers
	task automatic apply_setting(input logic [15:0] init, input logic [15:0] xo,
			input logic [7:0] c_cfg, input logic [7:0] c_set,
			input logic [7:0] c_req, input logic [7:0] c_ack);
		reg_write(REG_CRC_INIT, init);
		reg_write(REG_CRC_XOR, xo);
		reg_write(REG_CODE_CFG, 16'(c_cfg));
		reg_write(REG_CODE_SET, 16'(c_set));
		reg_write(REG_CODE_REQ, 16'(c_req));
		reg_write(REG_CODE_ACK, 16'(c_ack));
		settings++;
	endtask

	// one request on the byte channel, bursts with random gaps between them
	task automatic put_byte(input logic [7:0] b, input logic last);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 30);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				rx_ch.valid = 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		rx_ch.valid   = 1'b1;
		rx_ch.rx_byte = b;
		rx_ch.msg_end = last;
		do @(posedge clk); while (!rx_ch.ready);
		@(negedge clk);
		burst_left--;
		bytes_sent++;
	endtask

	task automatic send_message();
		for (int i = 0; i < msg_q.size(); i++) begin
			put_byte(msg_q[i], i == msg_q.size() - 1);
		end
		msgs_sent++;
	endtask

	// drop valid and let every outstanding result drain
	task automatic wait_idle();
		rx_ch.valid = 1'b0;
		while (chk_waiting != 0) @(negedge clk);
		repeat (6) @(negedge clk);
	endtask

	// frame check value over bytes 4 to 11 under the current setting
	function automatic logic [15:0] frame_fcs();
		logic [15:0] r;
		r = tb_crc_init;
		for (int i = 4; i < 12; i++) begin
			r = r ^ {msg_q[i], 8'h00};
			for (int k = 0; k < 8; k++) begin
				r = r[15] ? ({r[14:0], 1'b0} ^ CRC_POLY) : {r[14:0], 1'b0};
			end
		end
		return r ^ tb_crc_xor;
	endfunction

	// 14-byte frame, optionally with a broken check value or header
	task automatic build_frame(input msg_kind_t kind, input int mode_pick);
		logic [15:0] fcs;
		int pos;
		msg_q = {HDR_B0, HDR_B1, HDR_B2, HDR_B3};
		msg_q.push_back(mode_pick == PICK_ANY ? 8'($urandom()) : MODE_HI);
		msg_q.push_back(mode_pick == PICK_IAP ? MODE_IAP :
			mode_pick == PICK_APP ? MODE_APP : 8'($urandom()));
		repeat (6) msg_q.push_back(8'($urandom()));
		fcs = frame_fcs();
		if (kind == MSG_FRAME_CRC_BAD) begin
			fcs = fcs ^ 16'($urandom_range(1, 65535));
		end
		msg_q.push_back(fcs[15:8]);
		msg_q.push_back(fcs[7:0]);
		if (kind == MSG_FRAME_HDR_BAD) begin
			pos = $urandom_range(0, 3);
			msg_q[pos] = msg_q[pos] ^ 8'($urandom_range(1, 255));
		end
	endtask

	// random message of the given kind
	task automatic build_message(input msg_kind_t kind);
		int len;
		case (kind)
			MSG_CODE: begin
				case ($urandom_range(0, 4))
					0: msg_q = {tb_code_cfg};
					1: msg_q = {tb_code_set};
					2: msg_q = {tb_code_req};
					3: msg_q = {tb_code_ack};
					default: msg_q = {8'($urandom())};
				endcase
			end
			MSG_ODD_LEN: begin
				// short, mid-length or overlong; the count saturates past the frame size
				len = ($urandom_range(0, 1) == 0) ? $urandom_range(2, 13) : $urandom_range(15, 22);
				msg_q.delete();
				if (len >= 4 && $urandom_range(0, 1) == 0) begin
					msg_q = {HDR_B0, HDR_B1, HDR_B2, HDR_B3};
				end
				while (msg_q.size() < len) msg_q.push_back(8'($urandom()));
			end
			default: build_frame(kind, $urandom_range(PICK_IAP, PICK_ANY));
		endcase
	endtask

	// register setting for each phase: fixed corner settings first, then random
	task automatic phase_setting(input int phase);
		case (phase)
			0: apply_setting(16'h0000, 16'h0000, 8'h00, 8'h00, 8'h00, 8'h00);
			1: apply_setting(16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
			2: apply_setting(16'hFFFF, 16'h0000, 8'h11, 8'h22, 8'h22, 8'h22);
			3: apply_setting(16'h1D0F, 16'hFFFF, 8'h80, 8'h7F, 8'h55, 8'h55);
			default: apply_setting(16'($urandom()), 16'($urandom()),
				8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
				8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
		endcase
	endtask

	initial begin
		int phase;
		int phase_start;
		int roll;
		msg_kind_t kind;

		arst_n        = 1'b0;
		psel          = 1'b0;
		penable       = 1'b0;
		pwrite        = 1'b0;
		paddr         = '0;
		pwdata        = '0;
		rx_ch.valid   = 1'b0;
		rx_ch.rx_byte = '0;
		rx_ch.msg_end = 1'b0;
		res_ch.ready  = 1'b0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: reset codes, equal codes, unknown code, good frame, short message
		msg_q = {8'h00};
		send_message();
		msg_q = {8'h43};
		send_message();
		msg_q = {8'h06};
		send_message();
		msg_q = {8'hFF};
		send_message();
		build_frame(MSG_FRAME_OK, PICK_IAP);
		send_message();
		msg_q = {8'h80, 8'h7F};
		send_message();

		// random phases, each under its own register setting
		phase = 0;
		while (bytes_sent < BYTE_BUDGET) begin
			wait_idle();
			phase_setting(phase);
			phase_start = bytes_sent;
			while (bytes_sent - phase_start < PHASE_BYTES && bytes_sent < BYTE_BUDGET) begin
				roll = $urandom_range(0, 99);
				if (roll < 30) kind = MSG_CODE;
				else if (roll < 70) kind = MSG_FRAME_OK;
				else if (roll < 78) kind = MSG_FRAME_CRC_BAD;
				else if (roll < 85) kind = MSG_FRAME_HDR_BAD;
				else kind = MSG_ODD_LEN;
				build_message(kind);
				send_message();
			end
			phase++;
		end

		wait_idle();
		$display("sent %0d bytes in %0d messages across %0d register settings",
			bytes_sent, msgs_sent, settings);
		$display("checked %0d results, %0d failures", chk_reports, chk_fails);
		if (chk_fails == 0 && chk_waiting == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
